[src/shod_pkg.sv]
package shod_pkg;

   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
   localparam logic [31:0] MIX_MUL_A = 32'h85EB_CA6B;
   localparam logic [31:0] MIX_MUL_B = 32'hC2B2_AE35;
   localparam logic [31:0] SALT_PASS = 32'h0000_5C40;
   localparam logic [31:0] SALT_LOSS = 32'h0000_D0FF;

   localparam int          WORD_BYTES  = 4;
   localparam int          MSG_WORDS   = 5;
   localparam int          MSG_BITS    = 32 * MSG_WORDS;
   localparam int          PREFIX_LEN  = WORD_BYTES * MSG_WORDS;
   localparam int          LANE_COUNT  = 2;

   localparam int          THRESH_W    = 10;
   localparam int          QUOT_W      = 23;
   localparam logic [THRESH_W-1:0] DRAW_MOD = 10'd1000;
   // reciprocal of 1000, exact for every 32-bit dividend with a shift of 38
   localparam logic [31:0] DIV_MAGIC   = 32'h1062_4DD3;
   localparam int          DIV_SHIFT   = 38;

   localparam int          CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAIL_PER_MILLE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS_PER_MILLE = 8'd1;

   typedef struct packed {
      logic       en;
      logic       valid;
   } stage_ctl_type;

   typedef struct packed {
      logic [31:0] success_hash;
      logic [31:0] loss_hash;
      logic        succeeded;
      logic        was_lost;
   } result_type;

endpackage

[src/shod_fnv_cell.sv]
module shod_fnv_cell
   import shod_pkg::*;
#(
   parameter int MSG_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  stage_ctl_type    in_ctl,
   input  logic [31:0]      in_acc,
   input  logic [MSG_W-1:0] in_msg,
   output logic             out_valid,
   output logic [31:0]      out_acc,
   output logic [MSG_W-1:0] out_msg
);

   logic             valid_ff;
   logic [31:0]      acc_ff;
   logic [31:0]      acc_in;
   logic [MSG_W-1:0] msg_ff;
   logic [MSG_W-1:0] msg_in;

   // one fnv-1a byte step on the low byte, the rest moves on to the neighbor
   always_comb begin
      acc_in = 32'((in_acc ^ {24'd0, in_msg[7:0]}) * FNV_PRIME);
      msg_in = in_msg >> 8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ctl.en) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.en) begin
         acc_ff <= acc_in;
         msg_ff <= msg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_msg   = msg_ff;

endmodule

[src/shod_fmix_lane.sv]
module shod_fmix_lane
   import shod_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  stage_ctl_type       in_ctl,
   input  logic [31:0]         in_acc,
   output logic                out_valid,
   output logic [31:0]         out_hash,
   output logic [THRESH_W-1:0] out_rem
);

   logic [3:0]          valid_ff;
   logic [31:0]         m1_ff;
   logic [31:0]         m1_in;
   logic [31:0]         m2_ff;
   logic [31:0]         m2_in;
   logic [31:0]         h3_ff;
   logic [31:0]         h3_in;
   logic [QUOT_W-1:0]   q3_ff;
   logic [QUOT_W-1:0]   q3_in;
   logic [63:0]         prod;
   logic [31:0]         h4_ff;
   logic [THRESH_W-1:0] rem4_ff;
   logic [THRESH_W-1:0] rem4_in;
   logic [THRESH_W-1:0] qk_low;

   always_comb begin
      m1_in  = 32'((in_acc ^ (in_acc >> 16)) * MIX_MUL_A);
      m2_in  = 32'((m1_ff ^ (m1_ff >> 13)) * MIX_MUL_B);
      h3_in  = m2_ff ^ (m2_ff >> 16);
      prod   = 64'(h3_in) * 64'(DIV_MAGIC);
      q3_in  = prod[DIV_SHIFT +: QUOT_W];
      // remainder is below 1000, so only the low ten bits of h - q*1000 matter
      qk_low = THRESH_W'(2 * THRESH_W'(0) + q3_ff[THRESH_W-1:0] * DRAW_MOD);
      rem4_in = h3_ff[THRESH_W-1:0] - qk_low;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (in_ctl.en) begin
         valid_ff <= {valid_ff[2:0], in_ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.en) begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         h3_ff   <= h3_in;
         q3_ff   <= q3_in;
         h4_ff   <= h3_ff;
         rem4_ff <= rem4_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_hash  = h4_ff;
   assign out_rem   = rem4_ff;

endmodule

[src/salted_hash_outcome_draw.sv]
// Hashes seed, route, tick (low then high half) and owner byte by byte with
// 32-bit FNV-1a, once with salt 0x5C40 and once with 0xD0FF, runs each through
// the murmur3 finalizer and draws success and loss flags from the hashes mod
// 1000 against fail_per_mille (index 0) and loss_per_mille (index 1). One
// transaction is taken every cycle; a result passes through 20 byte cells
// shared by both salts, 4 salt byte cells per salt, a 4-stage finalizer with
// the mod-1000 reciprocal, and a 2-entry output queue. The pipeline holds
// only while that queue is full.
module salted_hash_outcome_draw
   import shod_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_seed_word,
   input  logic [31:0]            req_route_word,
   input  logic [63:0]            req_tick_value,
   input  logic [31:0]            req_owner_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_success_hash,
   output logic [31:0]            rsp_loss_hash,
   output logic                   rsp_succeeded,
   output logic                   rsp_was_lost,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THRESH_W-1:0]    csr_wdata
);

   logic [THRESH_W-1:0] fail_per_mille_ff;
   logic [THRESH_W-1:0] loss_per_mille_ff;

   logic                en;
   logic                c_vld [0:PREFIX_LEN];
   logic [31:0]         c_acc [0:PREFIX_LEN];
   logic [MSG_BITS-1:0] c_msg [0:PREFIX_LEN];
   logic                s_vld [0:LANE_COUNT-1][0:WORD_BYTES];
   logic [31:0]         s_acc [0:LANE_COUNT-1][0:WORD_BYTES];
   logic [31:0]         s_msg [0:LANE_COUNT-1][0:WORD_BYTES];
   logic                f_vld [0:LANE_COUNT-1];
   logic [31:0]         f_hash [0:LANE_COUNT-1];
   logic [THRESH_W-1:0] f_rem [0:LANE_COUNT-1];

   result_type          queue_ff [0:1];
   result_type          push_data;
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;
   logic                push;
   logic                pop;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_per_mille_ff <= '0;
         loss_per_mille_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FAIL_PER_MILLE: fail_per_mille_ff <= csr_wdata;
            CSR_LOSS_PER_MILLE: loss_per_mille_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the whole chain holds while the output queue is full
   assign en        = (count_ff != 2'd2);
   assign req_ready = en;

   assign c_vld[0] = req_valid;
   assign c_acc[0] = FNV_BASIS;
   assign c_msg[0] = {req_owner_word, req_tick_value[63:32], req_tick_value[31:0],
                      req_route_word, req_seed_word};

   for (genvar i = 0; i < PREFIX_LEN; i++) begin : g_prefix
      shod_fnv_cell #(.MSG_W(MSG_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    ('{en: en, valid: c_vld[i]}),
         .in_acc    (c_acc[i]),
         .in_msg    (c_msg[i]),
         .out_valid (c_vld[i+1]),
         .out_acc   (c_acc[i+1]),
         .out_msg   (c_msg[i+1])
      );
   end

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
      assign s_vld[l][0] = c_vld[PREFIX_LEN];
      assign s_acc[l][0] = c_acc[PREFIX_LEN];
      assign s_msg[l][0] = (l == 0) ? SALT_PASS : SALT_LOSS;

      for (genvar k = 0; k < WORD_BYTES; k++) begin : g_salt
         shod_fnv_cell #(.MSG_W(32)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_ctl    ('{en: en, valid: s_vld[l][k]}),
            .in_acc    (s_acc[l][k]),
            .in_msg    (s_msg[l][k]),
            .out_valid (s_vld[l][k+1]),
            .out_acc   (s_acc[l][k+1]),
            .out_msg   (s_msg[l][k+1])
         );
      end

      shod_fmix_lane u_fmix (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    ('{en: en, valid: s_vld[l][WORD_BYTES]}),
         .in_acc    (s_acc[l][WORD_BYTES]),
         .out_valid (f_vld[l]),
         .out_hash  (f_hash[l]),
         .out_rem   (f_rem[l])
      );
   end

   // outcome draw and output queue
   always_comb begin
      push_data.success_hash = f_hash[0];
      push_data.loss_hash    = f_hash[1];
      push_data.succeeded    = (f_rem[0] >= fail_per_mille_ff);
      push_data.was_lost     = !push_data.succeeded && (f_rem[1] < loss_per_mille_ff);
   end

   assign push = en && f_vld[0];
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid        = (count_ff != 2'd0);
   assign rsp_success_hash = queue_ff[rd_ptr_ff].success_hash;
   assign rsp_loss_hash    = queue_ff[rd_ptr_ff].loss_hash;
   assign rsp_succeeded    = queue_ff[rd_ptr_ff].succeeded;
   assign rsp_was_lost     = queue_ff[rd_ptr_ff].was_lost;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_full_holds_chain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !rsp_ready) |=> ($stable(f_hash[0]) && $stable(f_vld[0])))
      else $error("chain moved while output queue was full");

   a_lost_not_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_succeeded && rsp_was_lost))
      else $error("transaction both succeeded and lost");

   a_empty_after_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1 && pop && !push) |=> !rsp_valid)
      else $error("output queue not empty after last transaction left");

endmodule

[tb/sv/salted_hash_outcome_draw_tb.sv]
module salted_hash_outcome_draw_tb;
   import shod_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 1000;
   localparam int IDLE_PERCENT = 12;
   localparam int SWEEP_DRAWS  = 150;
   localparam int STEADY_DRAWS = 300;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP   = 8'hFF;
   localparam logic [THRESH_W-1:0]    THRESH_MAX      = 10'd1023;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [31:0]            req_seed_word  = '0;
   logic [31:0]            req_route_word = '0;
   logic [63:0]            req_tick_value = '0;
   logic [31:0]            req_owner_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [31:0]            rsp_success_hash;
   logic [31:0]            rsp_loss_hash;
   logic                   rsp_succeeded;
   logic                   rsp_was_lost;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [THRESH_W-1:0]    csr_wdata      = '0;

   // threshold registers as the block should hold them
   logic [THRESH_W-1:0] fail_mirror = '0;
   logic [THRESH_W-1:0] loss_mirror = '0;

   result_type pending_draws[$];
   bit         steady         = 1'b0;
   int         mismatch_count = 0;
   int         draws_checked  = 0;
   int         success_count  = 0;
   int         lost_count     = 0;
   int         settings_used  = 1;
   int         stall_cycles   = 0;

   salted_hash_outcome_draw dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] fnv_fold(input logic [31:0] acc, input logic [31:0] word);
      logic [31:0] h;
      h = acc;
      for (int b = 0; b < 4; b++)
         h = (h ^ {24'd0, word[8*b +: 8]}) * FNV_PRIME;
      return h;
   endfunction

   function automatic logic [31:0] salted_hash(input logic [31:0] seed, input logic [31:0] route,
                                               input logic [63:0] tick, input logic [31:0] owner,
                                               input logic [31:0] salt);
      logic [31:0] h;
      h = FNV_BASIS;
      h = fnv_fold(h, seed);
      h = fnv_fold(h, route);
      h = fnv_fold(h, tick[31:0]);
      h = fnv_fold(h, tick[63:32]);
      h = fnv_fold(h, owner);
      h = fnv_fold(h, salt);
      // murmur3 finalizer
      h = h ^ (h >> 16);
      h = h * MIX_MUL_A;
      h = h ^ (h >> 13);
      h = h * MIX_MUL_B;
      h = h ^ (h >> 16);
      return h;
   endfunction

   function automatic result_type predict_draw(input logic [31:0] seed, input logic [31:0] route,
                                               input logic [63:0] tick, input logic [31:0] owner);
      result_type r;
      r.success_hash = salted_hash(seed, route, tick, owner, SALT_PASS);
      r.loss_hash    = salted_hash(seed, route, tick, owner, SALT_LOSS);
      r.succeeded    = (r.success_hash % 32'd1000) >= 32'(fail_mirror);
      r.was_lost     = !r.succeeded && ((r.loss_hash % 32'd1000) < 32'(loss_mirror));
      return r;
   endfunction

   task automatic send_draw(input logic [31:0] seed, input logic [31:0] route,
                            input logic [63:0] tick, input logic [31:0] owner);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_seed_word  <= seed;
      req_route_word <= route;
      req_tick_value <= tick;
      req_owner_word <= owner;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_draws.push_back(predict_draw(seed, route, tick, owner));
   endtask

   task automatic random_draw();
      logic [31:0] seed;
      logic [31:0] route;
      logic [63:0] tick;
      logic [31:0] owner;
      seed  = $urandom;
      route = $urandom;
      tick  = {$urandom, $urandom};
      owner = $urandom;
      // now and then a realistic identity: early tick, few owners, small negative routes
      if ($urandom_range(9) == 0) begin
         tick  = 64'($urandom_range(100000));
         owner = $urandom_range(15);
         route = 32'(-$urandom_range(64));
      end
      send_draw(seed, route, tick, owner);
   endtask

   // lets the pipeline empty before touching the thresholds
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [THRESH_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_FAIL_PER_MILLE: fail_mirror = data;
         CSR_LOSS_PER_MILLE: loss_mirror = data;
         default: ;
      endcase
   endtask

   task automatic set_thresholds(input logic [THRESH_W-1:0] fail, input logic [THRESH_W-1:0] loss);
      quiesce();
      csr_write(CSR_FAIL_PER_MILLE, fail);
      csr_write(CSR_LOSS_PER_MILLE, loss);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic test_reset_thresholds();
      send_draw('0, '0, '0, '0);
      send_draw('1, '1, '1, '1);
      send_draw('1, '0, '0, '0);
      send_draw('0, '1, '0, '0);
      send_draw('0, '0, 64'h0000_0000_FFFF_FFFF, '0);
      send_draw('0, '0, 64'hFFFF_FFFF_0000_0000, '0);
      send_draw('0, '0, '0, '1);
      send_draw(32'hAAAA_AAAA, 32'h8000_0000, 64'h5555_5555_AAAA_AAAA, 32'h5555_5555);
      send_draw(32'h5555_5555, 32'hFFFF_FFFF, 64'hAAAA_AAAA_5555_5555, 32'hAAAA_AAAA);
   endtask

   task automatic test_threshold_extremes();
      // nothing succeeds, every failure is lost
      set_thresholds(10'd1000, 10'd1000);
      repeat (3) random_draw();
      // thresholds above the draw range or at its top end
      set_thresholds(THRESH_MAX, '0);
      repeat (2) random_draw();
      set_thresholds(10'd999, THRESH_MAX);
      repeat (2) random_draw();
   endtask

   task automatic test_unmapped_index();
      set_thresholds(10'd500, 10'd500);
      @(posedge clock);
      csr_write(CSR_INDEX_SPARE, '0);
      csr_write(CSR_INDEX_TOP, THRESH_MAX);
      csr_valid <= 1'b0;
      repeat (3) random_draw();
   endtask

   task automatic test_threshold_sweep();
      logic [THRESH_W-1:0] fail_set[$] = '{10'd0, 10'd1000, 10'd500, THRESH_MAX, 10'd999, 10'd1};
      logic [THRESH_W-1:0] loss_set[$] = '{10'd0, 10'd1000, 10'd500, THRESH_MAX, 10'd0, 10'd999};
      repeat (4) begin
         fail_set.push_back(THRESH_W'($urandom_range(1023)));
         loss_set.push_back(THRESH_W'($urandom_range(1023)));
      end
      foreach (fail_set[i]) begin
         set_thresholds(fail_set[i], loss_set[i]);
         repeat (SWEEP_DRAWS) random_draw();
      end
   endtask

   task automatic test_back_to_back();
      set_thresholds(THRESH_W'($urandom_range(1000)), THRESH_W'($urandom_range(1000)));
      steady = 1'b1;
      repeat (STEADY_DRAWS) random_draw();
      steady = 1'b0;
   endtask

   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %08h actual %08h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_draws.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none actual %08h %08h %b %b",
                     $time, rsp_success_hash, rsp_loss_hash, rsp_succeeded, rsp_was_lost);
            mismatch_count++;
         end else begin
            want = pending_draws.pop_front();
            check_field("success_hash", want.success_hash, rsp_success_hash);
            check_field("loss_hash", want.loss_hash, rsp_loss_hash);
            check_field("succeeded", 32'(want.succeeded), 32'(rsp_succeeded));
            check_field("was_lost", 32'(want.was_lost), 32'(rsp_was_lost));
            draws_checked++;
            success_count += rsp_succeeded;
            lost_count    += rsp_was_lost;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_thresholds();
      test_threshold_extremes();
      test_unmapped_index();
      test_threshold_sweep();
      test_back_to_back();
      quiesce();
      if (pending_draws.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_draws.size());
         mismatch_count++;
      end
      $display("checked %0d draws over %0d threshold settings: %0d succeeded, %0d lost",
               draws_checked, settings_used, success_count, lost_count);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
